>>> rtl/tpsm_pkg.sv
// ---------------------------------------------------------------------------
// tpsm_pkg
// shared types, widths and helpers for the triangle perspective screen map
// ---------------------------------------------------------------------------
`default_nettype none

package tpsm_pkg;

    // datapath widths
    localparam int COORD_W = 32;
    localparam int DIST_W  = 31;
    localparam int PROD_W  = 64;
    localparam int NUM_W   = 62;
    localparam int DEN_W   = 32;

    // stream payload widths
    localparam int IN_DATA_W  = 9 * COORD_W;
    localparam int OUT_DATA_W = 6 * COORD_W;
    localparam int IN_USER_W  = 3;
    localparam int OUT_USER_W = 2;

    // pipeline depth: input reg, multiply, magnitude, divider stages, output reg
    localparam int LAT = NUM_W + 4;

    // configuration register indexes
    localparam logic [1:0] REG_VIEW_DIST = 2'd0;
    localparam logic [1:0] REG_VP_WIDTH  = 2'd1;
    localparam logic [1:0] REG_VP_HEIGHT = 2'd2;

    localparam logic signed [COORD_W-1:0] S32_MAX = 32'sh7fff_ffff;
    localparam logic signed [COORD_W-1:0] S32_MIN = 32'sh8000_0000;

    // per-vertex sideband that rides beside the dividers
    typedef struct packed {
        logic                      draw;
        logic                      zero;
        logic                      xneg;
        logic                      yneg;
        logic                      zneg;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
    } t_side;

    // clamp a wide signed value to the signed 32-bit range
    function automatic logic signed [COORD_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
        logic signed [PROD_W-1:0] hi;
        logic signed [PROD_W-1:0] lo;
        hi = PROD_W'(S32_MAX);
        lo = PROD_W'(S32_MIN);
        if (v > hi) begin
            sat32 = S32_MAX;
        end else if (v < lo) begin
            sat32 = S32_MIN;
        end else begin
            sat32 = v[COORD_W-1:0];
        end
    endfunction

endpackage

`default_nettype wire

>>> rtl/tpsm_div.sv
// ---------------------------------------------------------------------------
// tpsm_div
// pipelined unsigned restoring divider, one quotient bit per stage
// ---------------------------------------------------------------------------
`default_nettype none

module tpsm_div
    import tpsm_pkg::*;
(
    input  wire                    i_clk,
    input  wire                    i_en,
    input  wire  [NUM_W-1:0]       i_num,
    input  wire  [DEN_W-1:0]       i_den,
    output logic [NUM_W-1:0]       o_quo
);

    // numerator bits shift out at the top while quotient bits shift in below
    logic [NUM_W-1:0] r_nq  [NUM_W];
    logic [DEN_W-1:0] r_rem [NUM_W];
    logic [DEN_W-1:0] r_den [NUM_W];

    genvar k;
    generate
        for (k = 0; k < NUM_W; k++) begin : g_stage
            logic [NUM_W-1:0] w_nq;
            logic [DEN_W-1:0] w_rem;
            logic [DEN_W-1:0] w_den;
            logic [DEN_W:0]   w_trial;
            logic [DEN_W:0]   w_diff;
            logic             w_ge;

            // stage source
            if (k == 0) begin : g_first
                assign w_nq  = i_num;
                assign w_rem = '0;
                assign w_den = i_den;
            end else begin : g_next
                assign w_nq  = r_nq[k-1];
                assign w_rem = r_rem[k-1];
                assign w_den = r_den[k-1];
            end

            // one compare and subtract
            assign w_trial = {w_rem, w_nq[NUM_W-1]};
            assign w_diff  = w_trial - {1'b0, w_den};
            assign w_ge    = (w_trial >= {1'b0, w_den});

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_nq[k]  <= {w_nq[NUM_W-2:0], w_ge};
                    r_rem[k] <= w_ge ? w_diff[DEN_W-1:0] : w_trial[DEN_W-1:0];
                    r_den[k] <= w_den;
                end
            end
        end
    endgenerate

    assign o_quo = r_nq[NUM_W-1];

endmodule

`default_nettype wire

>>> rtl/tpsm_vert.sv
// ---------------------------------------------------------------------------
// tpsm_vert
// projects one vertex, or passes it through unchanged when not drawn: multiply, magnitude, divide, offset and saturate
// ---------------------------------------------------------------------------
`default_nettype none

module tpsm_vert
    import tpsm_pkg::*;
(
    input  wire                         i_clk,
    input  wire                         i_en,
    input  wire                         i_draw,
    input  wire  [DIST_W-1:0]           i_dist,
    input  wire  signed [PROD_W-1:0]    i_offx,
    input  wire  signed [PROD_W-1:0]    i_offy,
    input  wire  signed [COORD_W-1:0]   i_x,
    input  wire  signed [COORD_W-1:0]   i_y,
    input  wire  signed [COORD_W-1:0]   i_z,
    output logic signed [COORD_W-1:0]   o_sx,
    output logic signed [COORD_W-1:0]   o_sy,
    output logic                        o_fault,
    output logic                        o_drawn
);

    // multiply stage
    logic signed [PROD_W-1:0]  r_nx;
    logic signed [PROD_W-1:0]  r_ny;
    logic signed [COORD_W-1:0] r_x1;
    logic signed [COORD_W-1:0] r_y1;
    logic signed [COORD_W-1:0] r_z1;
    logic                      r_draw1;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_nx    <= PROD_W'($signed({1'b0, i_dist}) * i_x);
            r_ny    <= PROD_W'($signed({1'b0, i_dist}) * i_y);
            r_x1    <= i_x;
            r_y1    <= i_y;
            r_z1    <= i_z;
            r_draw1 <= i_draw;
        end
    end

    // magnitude stage
    logic [NUM_W-1:0] r_nxm;
    logic [NUM_W-1:0] r_nym;
    logic [DEN_W-1:0] r_zm;
    t_side            r_side2;
    logic [PROD_W-1:0] w_nxa;
    logic [PROD_W-1:0] w_nya;
    logic [COORD_W-1:0] w_za;

    assign w_nxa = r_nx[PROD_W-1] ? PROD_W'(-r_nx) : r_nx;
    assign w_nya = r_ny[PROD_W-1] ? PROD_W'(-r_ny) : r_ny;
    assign w_za  = r_z1[COORD_W-1] ? COORD_W'(-r_z1) : r_z1;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_nxm        <= w_nxa[NUM_W-1:0];
            r_nym        <= w_nya[NUM_W-1:0];
            r_zm         <= w_za;
            r_side2.draw <= r_draw1;
            r_side2.zero <= (r_z1 == '0);
            r_side2.xneg <= r_nx[PROD_W-1];
            r_side2.yneg <= r_ny[PROD_W-1];
            r_side2.zneg <= r_z1[COORD_W-1];
            r_side2.x    <= r_x1;
            r_side2.y    <= r_y1;
        end
    end

    // dividers
    logic [NUM_W-1:0] w_qx;
    logic [NUM_W-1:0] w_qy;

    tpsm_div u_div_x (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_num (r_nxm),
        .i_den (r_zm),
        .o_quo (w_qx)
    );

    tpsm_div u_div_y (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_num (r_nym),
        .i_den (r_zm),
        .o_quo (w_qy)
    );

    // sideband delay matching the dividers
    t_side r_side [NUM_W];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side[0] <= r_side2;
            for (int i = 1; i < NUM_W; i++) begin
                r_side[i] <= r_side[i-1];
            end
        end
    end

    // sign, offset and saturate into the output register
    t_side                    w_s;
    logic signed [PROD_W-1:0] w_qxs;
    logic signed [PROD_W-1:0] w_qys;
    logic signed [COORD_W-1:0] n_sx;
    logic signed [COORD_W-1:0] n_sy;

    assign w_s = r_side[NUM_W-1];

    always_comb begin
        w_qxs = $signed({2'b00, w_qx});
        w_qys = $signed({2'b00, w_qy});
        if (w_s.xneg ^ w_s.zneg) begin
            w_qxs = -w_qxs;
        end
        if (w_s.yneg ^ w_s.zneg) begin
            w_qys = -w_qys;
        end
        if (!w_s.draw) begin
            n_sx = w_s.x;
            n_sy = w_s.y;
        end else if (w_s.zero) begin
            n_sx = w_s.xneg ? S32_MIN : S32_MAX;
            n_sy = w_s.yneg ? S32_MAX : S32_MIN;
        end else begin
            n_sx = sat32(w_qxs + i_offx);
            n_sy = sat32(i_offy - w_qys);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_sx    <= n_sx;
            o_sy    <= n_sy;
            o_fault <= w_s.draw & w_s.zero;
            o_drawn <= w_s.draw;
        end
    end

endmodule

`default_nettype wire

>>> rtl/triangle_perspective_screen_map.sv
// ---------------------------------------------------------------------------
// triangle_perspective_screen_map
// maps a camera-space triangle to screen coordinates
// ---------------------------------------------------------------------------
// Input stream: one triangle per request; tuser carries the active, clipped
// and back-facing flags, tdata the nine vertex coordinates in signed fixed
// point. Output stream: one request per triangle; tuser carries drawn and
// the divide fault, tdata the six screen coordinates, saturated to 32 bits.
// The APB port holds view distance and viewport size; write it only while
// no triangle is in flight.
// Each triangle passes the input, multiply and magnitude registers, the
// 62-stage restoring divider (one quotient bit per stage) and the output
// register. Throughput is one triangle per cycle while the receiver
// accepts; all six divisions run in their own pipelined dividers.
// When the receiver stalls, the whole pipeline holds and s_axis_tready
// drops only while the output register is full and not taken; nothing is
// lost or repeated. A synchronous reset empties the pipeline and restores
// the registers to d = 1.0 and a 640 x 480 viewport.
// ---------------------------------------------------------------------------
`default_nettype none

module triangle_perspective_screen_map
    import tpsm_pkg::*;
#(
    parameter int COORD_FRAC_BITS = 16,
    parameter int VIEWPORT_BITS   = 13
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    // apb configuration
    input  wire                     psel,
    input  wire                     penable,
    input  wire                     pwrite,
    input  wire  [3:0]              paddr,
    input  wire  [31:0]             pwdata,
    output logic [31:0]             prdata,
    output logic                    pready,
    // input stream
    input  wire                     s_axis_tvalid,
    output logic                    s_axis_tready,
    input  wire  [IN_DATA_W-1:0]    s_axis_tdata,  // v0_x v0_y v0_z v1_x v1_y v1_z v2_x v2_y v2_z
    input  wire  [IN_USER_W-1:0]    s_axis_tuser,  // poly_active poly_clipped poly_backface
    // output stream
    output logic                    m_axis_tvalid,
    input  wire                     m_axis_tready,
    output logic [OUT_DATA_W-1:0]   m_axis_tdata,  // v0_sx v0_sy v1_sx v1_sy v2_sx v2_sy
    output logic [OUT_USER_W-1:0]   m_axis_tuser   // drawn div_fault
);

    // configuration registers
    logic [DIST_W-1:0]        r_dist;
    logic [VIEWPORT_BITS-1:0] r_vpw;
    logic [VIEWPORT_BITS-1:0] r_vph;
    logic                     w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dist <= DIST_W'(65536);
            r_vpw  <= VIEWPORT_BITS'(640);
            r_vph  <= VIEWPORT_BITS'(480);
        end else if (w_wr) begin
            case (paddr[3:2])
                REG_VIEW_DIST: r_dist <= pwdata[DIST_W-1:0];
                REG_VP_WIDTH:  r_vpw  <= pwdata[VIEWPORT_BITS-1:0];
                REG_VP_HEIGHT: r_vph  <= pwdata[VIEWPORT_BITS-1:0];
                default:       ;
            endcase
        end
    end

    // register read back
    always_comb begin
        case (paddr[3:2])
            REG_VIEW_DIST: prdata = 32'({1'b0, r_dist});
            REG_VP_WIDTH:  prdata = 32'(r_vpw);
            REG_VP_HEIGHT: prdata = 32'(r_vph);
            default:       prdata = '0;
        endcase
    end

    // half-viewport offsets in fixed point, registered from static config
    logic signed [PROD_W-1:0] r_offx;
    logic signed [PROD_W-1:0] r_offy;

    always_ff @(posedge i_clk) begin
        r_offx <= ($signed({{(PROD_W-VIEWPORT_BITS){1'b0}}, r_vpw}) - PROD_W'(1))
                  <<< (COORD_FRAC_BITS - 1);
        r_offy <= ($signed({{(PROD_W-VIEWPORT_BITS){1'b0}}, r_vph}) - PROD_W'(1))
                  <<< (COORD_FRAC_BITS - 1);
    end

    // pipeline advance and valid chain
    logic           w_adv;
    logic [LAT-1:0] r_vld;

    assign w_adv         = !r_vld[LAT-1] || m_axis_tready;
    assign s_axis_tready = w_adv;
    assign m_axis_tvalid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[LAT-2:0], s_axis_tvalid};
        end
    end

    // input register
    logic [IN_DATA_W-1:0] r_in;
    logic                 r_draw;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_in   <= s_axis_tdata;
            r_draw <= s_axis_tuser[0] & ~s_axis_tuser[1] & ~s_axis_tuser[2];
        end
    end

    // three vertex lanes
    logic [2:0] w_fault;
    logic [2:0] w_drawn;

    genvar v;
    generate
        for (v = 0; v < 3; v++) begin : g_vert
            tpsm_vert u_vert (
                .i_clk   (i_clk),
                .i_en    (w_adv),
                .i_draw  (r_draw),
                .i_dist  (r_dist),
                .i_offx  (r_offx),
                .i_offy  (r_offy),
                .i_x     ($signed(r_in[(3*v)*COORD_W +: COORD_W])),
                .i_y     ($signed(r_in[(3*v+1)*COORD_W +: COORD_W])),
                .i_z     ($signed(r_in[(3*v+2)*COORD_W +: COORD_W])),
                .o_sx    (m_axis_tdata[(2*v)*COORD_W +: COORD_W]),
                .o_sy    (m_axis_tdata[(2*v+1)*COORD_W +: COORD_W]),
                .o_fault (w_fault[v]),
                .o_drawn (w_drawn[v])
            );
        end
    endgenerate

    assign m_axis_tuser = {|w_fault, w_drawn[0]};

`ifndef SYNTHESIS
    // a triangle passed through never reports a divide fault
    a_fault_needs_draw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> !m_axis_tuser[1])
        else $error("divide fault on a pass-through triangle");

    // reset empties the output
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid right after reset");

    // at most one triangle enters the pipeline per cycle
    a_one_per_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> $countones(r_vld) <= $countones($past(r_vld)) + 1)
        else $error("pipeline occupancy grew by more than one");

    // all lanes agree on the drawn flag
    a_lanes_agree: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (w_drawn[1] == w_drawn[0]) && (w_drawn[2] == w_drawn[0]))
        else $error("vertex lanes out of step");
`endif

endmodule

`default_nettype wire
